/* src/kct_pkg.sv */
// Shared constants, codes and request/response types of the k-mer count table.
package kct_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int MAX_SAMPLES = 8;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int SMP_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int USED_W = $clog2(TABLE_DEPTH + 1);
    localparam int NS_W   = $clog2(MAX_SAMPLES + 1);
    localparam int CADR_W = IDX_W + SMP_W;
    localparam int CNT_DEPTH = TABLE_DEPTH * (2 ** SMP_W);

    localparam int KEY_W      = 64;
    localparam int CNT_W      = 32;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int MODE_W     = 2;
    localparam int SIDX_W     = 3;
    localparam int STAT_W     = 2;
    localparam int USED_OUT_W = 11;

    localparam logic [MODE_W-1:0] MODE_GET    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INC    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FILTER = 2'd3;

    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_SAT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 1'd1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [SIDX_W-1:0] sidx;
        logic [CNT_W-1:0]  value;
    } req_t;

    typedef struct packed {
        logic [CNT_W-1:0]      count;
        logic                  found;
        logic [STAT_W-1:0]     status;
        logic [USED_OUT_W-1:0] used;
    } rsp_t;

endpackage

/* src/kmer_count_table.sv */
// Get/set/increment scan the key memory slot by slot (read, then compare) up to the hit,
// or through all TABLE_DEPTH slots on a miss; a create first zeroes all MAX_SAMPLES counters.
// Filter reads every slot; for a used slot it also reads and tests each configured sample.
// One request at a time; the result register frees the engine for the next request.
// Reset is asynchronous, active low; after it a pass over every slot clears the
// valid bits in the key memory while in_stall stays high.
module kmer_count_table (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [kct_pkg::MODE_W-1:0]        mode,
    input  logic [kct_pkg::KEY_W-1:0]         kmer_key,
    input  logic [kct_pkg::SIDX_W-1:0]        sample_index,
    input  logic [kct_pkg::CNT_W-1:0]         count_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [kct_pkg::CNT_W-1:0]         count_out,
    output logic                              key_found,
    output logic [kct_pkg::STAT_W-1:0]        status,
    output logic [kct_pkg::USED_OUT_W-1:0]    entries_used,
    input  logic                              cfg_we,
    input  logic [kct_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kct_pkg::CFG_W-1:0]         cfg_data
);

    logic [kct_pkg::CFG_W-1:0] sample_count_reg;
    logic [kct_pkg::CFG_W-1:0] threshold_reg;
    logic                      out_valid_reg;
    kct_pkg::rsp_t             out_reg;
    kct_pkg::req_t             req;
    kct_pkg::rsp_t             rsp;
    logic                      req_ready;
    logic                      rsp_valid;
    logic                      rsp_ready;

    assign req.mode  = mode;
    assign req.key   = kmer_key;
    assign req.sidx  = sample_index;
    assign req.value = count_value;

    assign in_stall  = !req_ready;
    assign rsp_ready = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign count_out    = out_reg.count;
    assign key_found    = out_reg.found;
    assign status       = out_reg.status;
    assign entries_used = out_reg.used;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= kct_pkg::CFG_W'(1);
            threshold_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kct_pkg::REG_SAMPLE_COUNT: sample_count_reg <= cfg_data;
                kct_pkg::REG_THRESHOLD:    threshold_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= rsp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
        begin
            out_reg <= rsp;
        end
    end

    kct_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (in_valid),
        .req_ready    (req_ready),
        .req          (req),
        .sample_count (sample_count_reg),
        .threshold    (threshold_reg),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp)
    );

endmodule

/* src/kct_ram.sv */
// Generic simple dual-port RAM with registered read.
module kct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/kct_engine.sv */
// Sequencer that scans, updates and filters the key and count memories.
module kct_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  kct_pkg::req_t                req,
    input  logic [kct_pkg::CFG_W-1:0]    sample_count,
    input  logic [kct_pkg::CFG_W-1:0]    threshold,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output kct_pkg::rsp_t                rsp
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_ACT, S_ZERO, S_RMW,
        S_GET_WAIT, S_INC_WAIT, S_F_RD, S_F_CHK, S_F_CNT, S_F_ACC, S_F_DEC, S_RESP
    } state_t;

    state_t                        state_reg;
    kct_pkg::req_t                 req_reg;
    logic [kct_pkg::IDX_W-1:0]     addr_reg;
    logic [kct_pkg::IDX_W-1:0]     slot_reg;
    logic [kct_pkg::IDX_W-1:0]     free_reg;
    logic                          free_found_reg;
    logic                          found_reg;
    logic [kct_pkg::CNT_W-1:0]     count_reg;
    logic [kct_pkg::STAT_W-1:0]    status_reg;
    logic [kct_pkg::USED_W-1:0]    used_reg;
    logic [kct_pkg::SMP_W-1:0]     sub_reg;
    logic [kct_pkg::NS_W-1:0]      rec_reg;

    logic                          key_we;
    logic [kct_pkg::IDX_W-1:0]     key_waddr;
    logic [kct_pkg::KEY_W:0]       key_wdata;
    logic [kct_pkg::IDX_W-1:0]     key_raddr;
    logic [kct_pkg::KEY_W:0]       key_rdata;
    logic                          cnt_we;
    logic [kct_pkg::CADR_W-1:0]    cnt_waddr;
    logic [kct_pkg::CNT_W-1:0]     cnt_wdata;
    logic [kct_pkg::CADR_W-1:0]    cnt_raddr;
    logic [kct_pkg::CNT_W-1:0]     cnt_rdata;

    logic [kct_pkg::NS_W-1:0]      nsamp;
    logic [kct_pkg::SMP_W-1:0]     sidx_s;
    logic                          in_range;
    logic                          last;
    logic                          entry_valid;
    logic                          key_hit;
    logic                          create;
    logic [kct_pkg::CNT_W:0]       sum;
    logic                          drop;

    assign nsamp = (int'(sample_count) > kct_pkg::MAX_SAMPLES)
                   ? kct_pkg::NS_W'(kct_pkg::MAX_SAMPLES)
                   : kct_pkg::NS_W'(sample_count);
    assign sidx_s      = kct_pkg::SMP_W'(req_reg.sidx);
    assign in_range    = int'(req_reg.sidx) < int'(nsamp);
    assign last        = (addr_reg == kct_pkg::IDX_W'(kct_pkg::TABLE_DEPTH - 1));
    assign entry_valid = key_rdata[kct_pkg::KEY_W];
    assign key_hit     = entry_valid && (key_rdata[kct_pkg::KEY_W-1:0] == req_reg.key);
    assign create      = in_range && (req_reg.mode != kct_pkg::MODE_GET) && !found_reg
                         && free_found_reg;
    assign sum         = {1'b0, cnt_rdata} + {1'b0, req_reg.value};
    assign drop        = int'(rec_reg) < int'(threshold);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_RESP);
    assign rsp.count  = count_reg;
    assign rsp.found  = found_reg;
    assign rsp.status = status_reg;
    assign rsp.used   = kct_pkg::USED_OUT_W'(used_reg);

    always_comb
    begin
        key_we    = 1'b0;
        key_waddr = addr_reg;
        key_wdata = '0;
        key_raddr = addr_reg;
        cnt_we    = 1'b0;
        cnt_waddr = {slot_reg, sidx_s};
        cnt_wdata = req_reg.value;
        cnt_raddr = {slot_reg, sidx_s};
        case (state_reg)
            S_CLEAR:
            begin
                key_we = 1'b1;
            end
            S_ACT:
            begin
                if (create)
                begin
                    key_we    = 1'b1;
                    key_waddr = free_reg;
                    key_wdata = {1'b1, req_reg.key};
                end
            end
            S_ZERO:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = {slot_reg, sub_reg};
                cnt_wdata = '0;
            end
            S_RMW:
            begin
                cnt_we = (req_reg.mode == kct_pkg::MODE_SET);
            end
            S_INC_WAIT:
            begin
                cnt_we    = 1'b1;
                cnt_wdata = sum[kct_pkg::CNT_W] ? '1 : sum[kct_pkg::CNT_W-1:0];
            end
            S_F_CNT:
            begin
                cnt_raddr = {addr_reg, sub_reg};
            end
            S_F_DEC:
            begin
                key_we = drop;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            addr_reg       <= '0;
            used_reg       <= '0;
            free_found_reg <= 1'b0;
            found_reg      <= 1'b0;
            status_reg     <= kct_pkg::STATUS_OK;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg        <= req;
                        addr_reg       <= '0;
                        found_reg      <= 1'b0;
                        free_found_reg <= 1'b0;
                        count_reg      <= '0;
                        status_reg     <= kct_pkg::STATUS_OK;
                        state_reg      <= (req.mode == kct_pkg::MODE_FILTER) ? S_F_RD
                                                                              : S_SCAN_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CMP;
                end
                S_SCAN_CMP:
                begin
                    if (key_hit)
                    begin
                        found_reg <= 1'b1;
                        slot_reg  <= addr_reg;
                        state_reg <= S_ACT;
                    end
                    else
                    begin
                        // remember the lowest free slot for a possible create
                        if (!entry_valid && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_reg       <= addr_reg;
                        end
                        addr_reg  <= addr_reg + 1'b1;
                        state_reg <= last ? S_ACT : S_SCAN_RD;
                    end
                end
                S_ACT:
                begin
                    if (!in_range)
                    begin
                        state_reg <= S_RESP;
                    end
                    else if (req_reg.mode == kct_pkg::MODE_GET)
                    begin
                        state_reg <= found_reg ? S_GET_WAIT : S_RESP;
                    end
                    else if (found_reg)
                    begin
                        state_reg <= S_RMW;
                    end
                    else if (!free_found_reg)
                    begin
                        status_reg <= kct_pkg::STATUS_FULL;
                        state_reg  <= S_RESP;
                    end
                    else
                    begin
                        slot_reg  <= free_reg;
                        used_reg  <= used_reg + 1'b1;
                        sub_reg   <= '0;
                        state_reg <= S_ZERO;
                    end
                end
                S_ZERO:
                begin
                    sub_reg <= sub_reg + 1'b1;
                    if (sub_reg == kct_pkg::SMP_W'(kct_pkg::MAX_SAMPLES - 1))
                    begin
                        state_reg <= S_RMW;
                    end
                end
                S_RMW:
                begin
                    if (req_reg.mode == kct_pkg::MODE_SET)
                    begin
                        count_reg <= req_reg.value;
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_INC_WAIT;
                    end
                end
                S_GET_WAIT:
                begin
                    count_reg <= cnt_rdata;
                    state_reg <= S_RESP;
                end
                S_INC_WAIT:
                begin
                    if (sum[kct_pkg::CNT_W])
                    begin
                        count_reg  <= '1;
                        status_reg <= kct_pkg::STATUS_SAT;
                    end
                    else
                    begin
                        count_reg <= sum[kct_pkg::CNT_W-1:0];
                    end
                    state_reg <= S_RESP;
                end
                S_F_RD:
                begin
                    state_reg <= S_F_CHK;
                end
                S_F_CHK:
                begin
                    sub_reg <= '0;
                    rec_reg <= '0;
                    if (!entry_valid)
                    begin
                        addr_reg  <= addr_reg + 1'b1;
                        state_reg <= last ? S_RESP : S_F_RD;
                    end
                    else
                    begin
                        state_reg <= (nsamp == '0) ? S_F_DEC : S_F_CNT;
                    end
                end
                S_F_CNT:
                begin
                    state_reg <= S_F_ACC;
                end
                S_F_ACC:
                begin
                    if (cnt_rdata != '0)
                    begin
                        rec_reg <= rec_reg + 1'b1;
                    end
                    sub_reg <= sub_reg + 1'b1;
                    state_reg <= (int'(sub_reg) + 1 >= int'(nsamp)) ? S_F_DEC : S_F_CNT;
                end
                S_F_DEC:
                begin
                    if (drop)
                    begin
                        used_reg <= used_reg - 1'b1;
                    end
                    addr_reg  <= addr_reg + 1'b1;
                    state_reg <= last ? S_RESP : S_F_RD;
                end
                S_RESP:
                begin
                    if (rsp_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    kct_ram #(
        .WIDTH (kct_pkg::KEY_W + 1),
        .DEPTH (kct_pkg::TABLE_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    kct_ram #(
        .WIDTH (kct_pkg::CNT_W),
        .DEPTH (kct_pkg::CNT_DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

endmodule

/* src/kct_checker.sv */
// Port-level checks on the k-mer count table, bound to the top level.
module kct_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [kct_pkg::CNT_W-1:0]         count_out,
    input logic [kct_pkg::STAT_W-1:0]        status,
    input logic [kct_pkg::USED_OUT_W-1:0]    entries_used
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(count_out))
        else $error("result dropped or changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == kct_pkg::STATUS_OK || status == kct_pkg::STATUS_FULL
                      || status == kct_pkg::STATUS_SAT)
        else $error("status code out of range");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == kct_pkg::STATUS_FULL |-> count_out == '0
                      && int'(entries_used) == kct_pkg::TABLE_DEPTH)
        else $error("full status with nonzero count or free slots");

    a_sat_ones: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == kct_pkg::STATUS_SAT |-> count_out == '1)
        else $error("saturated status without saturated count");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(entries_used) <= kct_pkg::TABLE_DEPTH)
        else $error("entry count beyond table depth");

endmodule

bind kmer_count_table kct_checker u_kct_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .count_out    (count_out),
    .status       (status),
    .entries_used (entries_used)
);

/* verif/tb_kmer_count_table.sv */
// Self-checking testbench for the k-mer count table: directed table, then random traffic.
module tb_kmer_count_table;
    timeunit 1ns;
    timeprecision 1ps;
    import kct_pkg::*;

    localparam int STALL_LIMIT = 100000;
    localparam int POOL_SIZE   = 40;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] cidx;
        logic [CFG_W-1:0]     cdata;
        req_t                 req;
        bit                   typed;
        rsp_t                 want;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [MODE_W-1:0]     mode = MODE_GET;
    logic [KEY_W-1:0]      kmer_key = '0;
    logic [SIDX_W-1:0]     sample_index = '0;
    logic [CNT_W-1:0]      count_value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [CNT_W-1:0]      count_out;
    logic                  key_found;
    logic [STAT_W-1:0]     status;
    logic [USED_OUT_W-1:0] entries_used;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_SAMPLE_COUNT;
    logic [CFG_W-1:0]      cfg_data = '0;

    kmer_count_table dut (.*);

    always #10 clk = ~clk;

    // table shadow and register copies
    logic [KEY_W-1:0] shadow_key [TABLE_DEPTH];
    bit               shadow_live [TABLE_DEPTH];
    logic [CNT_W-1:0] shadow_cnt [TABLE_DEPTH][MAX_SAMPLES];
    int               shadow_used = 0;
    int               samples_cfg = 1;
    int               thresh_cfg = 0;

    rsp_t             pending_rsp[$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    plan_row_t        plan[$];
    int tx_pct = 0, rx_pct = 0;
    int mismatches = 0, requests_done = 0, responses_seen = 0;
    int filters_sent = 0, full_seen = 0, sat_seen = 0;
    int idle_cycles = 0;

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++)
            shadow_live[i] = 1'b0;
    end

    function automatic rsp_t table_apply(req_t r);
        rsp_t        o;
        int          slot;
        int          live_samples;
        int          nonzero;
        logic [32:0] sum;
        o = '0;
        live_samples = (samples_cfg > MAX_SAMPLES) ? MAX_SAMPLES : samples_cfg;
        if (r.mode == MODE_FILTER) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (shadow_live[i]) begin
                    nonzero = 0;
                    for (int s = 0; s < live_samples; s++)
                        if (shadow_cnt[i][s] != 0)
                            nonzero++;
                    if (nonzero < thresh_cfg) begin
                        shadow_live[i] = 1'b0;
                        shadow_used--;
                    end
                end
            end
        end else begin
            slot = -1;
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (slot < 0 && shadow_live[i] && shadow_key[i] == r.key)
                    slot = i;
            o.found = (slot >= 0);
            if (r.sidx < live_samples) begin
                if (r.mode == MODE_GET) begin
                    if (slot >= 0)
                        o.count = shadow_cnt[slot][r.sidx];
                end else begin
                    // new key takes the lowest free slot, zeroed
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (slot < 0 && !shadow_live[i]) begin
                            slot = i;
                            shadow_live[i] = 1'b1;
                            shadow_key[i] = r.key;
                            for (int s = 0; s < MAX_SAMPLES; s++)
                                shadow_cnt[i][s] = '0;
                            shadow_used++;
                        end
                    end
                    if (slot < 0) begin
                        o.status = STATUS_FULL;
                    end else if (r.mode == MODE_SET) begin
                        shadow_cnt[slot][r.sidx] = r.value;
                        o.count = r.value;
                    end else begin
                        sum = {1'b0, shadow_cnt[slot][r.sidx]} + {1'b0, r.value};
                        if (sum[32]) begin
                            sum = 33'h0_FFFF_FFFF;
                            o.status = STATUS_SAT;
                        end
                        shadow_cnt[slot][r.sidx] = sum[31:0];
                        o.count = sum[31:0];
                    end
                end
            end
        end
        o.used = shadow_used[USED_OUT_W-1:0];
        return o;
    endfunction

    function automatic plan_row_t op(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
                                     logic [SIDX_W-1:0] s, logic [CNT_W-1:0] v);
        plan_row_t p;
        p = '{default: '0};
        p.req = '{mode: m, key: k, sidx: s, value: v};
        return p;
    endfunction

    function automatic plan_row_t op_chk(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
                                         logic [SIDX_W-1:0] s, logic [CNT_W-1:0] v,
                                         logic [CNT_W-1:0] c, logic f,
                                         logic [STAT_W-1:0] st, int u);
        plan_row_t p;
        p = op(m, k, s, v);
        p.typed = 1'b1;
        p.want = '{count: c, found: f, status: st, used: u[USED_OUT_W-1:0]};
        return p;
    endfunction

    function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
        plan_row_t p;
        p = '{default: '0};
        p.is_cfg = 1'b1;
        p.cidx = idx;
        p.cdata = d;
        return p;
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   pick;
        pick = $urandom_range(99);
        r.mode = (pick < 30) ? MODE_GET : (pick < 57) ? MODE_SET :
                 (pick < 96) ? MODE_INC : MODE_FILTER;
        r.key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                          : {$urandom(), $urandom()};
        r.sidx = SIDX_W'($urandom_range(7));
        case ($urandom_range(3))
            0: r.value = $urandom();
            1: r.value = $urandom_range(15);
            2: r.value = 32'hFFFF_FFFF - $urandom_range(3);
            default: r.value = $urandom() | 32'h8000_0000;
        endcase
        return r;
    endfunction

    // call right after a rising edge; returns right after the accepting edge, or later when tx_pct idles
    task automatic send_request(req_t r, bit typed, rsp_t want);
        rsp_t p;
        mode <= r.mode;
        kmer_key <= r.key;
        sample_index <= r.sidx;
        count_value <= r.value;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        p = table_apply(r);
        pending_rsp.insert(pending_rsp.size(), typed ? want : p);
        requests_done++;
        if (r.mode == MODE_FILTER)
            filters_sent++;
        if (p.status == STATUS_FULL)
            full_seen++;
        if (p.status == STATUS_SAT)
            sat_seen++;
        if ($urandom_range(99) < tx_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_pct)
                @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SAMPLE_COUNT)
            samples_cfg = int'(d);
        else
            thresh_cfg = int'(d);
    endtask

    // response checking, receiver stall and watchdog
    always @(posedge clk) begin
        rsp_t exp_rsp;
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("tb_kmer_count_table: done, errors");
                $finish;
            end
            if (out_valid && !out_stall) begin
                responses_seen++;
                if (pending_rsp.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response count=%h", count_out);
                end else begin
                    exp_rsp = pending_rsp.pop_front();
                    if (count_out !== exp_rsp.count || key_found !== exp_rsp.found ||
                        status !== exp_rsp.status || entries_used !== exp_rsp.used) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("response %0d: exp cnt=%h fnd=%b st=%0d used=%0d, %s",
                                     responses_seen, exp_rsp.count, exp_rsp.found,
                                     exp_rsp.status, exp_rsp.used,
                                     $sformatf("got cnt=%h fnd=%b st=%0d used=%0d",
                                               count_out, key_found, status,
                                               entries_used));
                    end
                end
            end
        end
        out_stall <= ($urandom_range(99) < rx_pct);
    end

    initial begin
        rsp_t none;
        none = '0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom(), $urandom()};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        plan = {plan, reg_row(REG_SAMPLE_COUNT, 4'd1)};
        plan = {plan, reg_row(REG_THRESHOLD, 4'd0)};
        plan = {plan, op_chk(MODE_GET, '0, 0, 0, 0, 0, STATUS_OK, 0)};
        plan = {plan, op_chk(MODE_SET, '0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, STATUS_OK, 1)};
        plan = {plan, op_chk(MODE_INC, '0, 0, 1, 32'hFFFF_FFFF, 1, STATUS_SAT, 1)};
        plan = {plan, op_chk(MODE_GET, '0, 0, 0, 32'hFFFF_FFFF, 1, STATUS_OK, 1)};
        // out-of-range sample: nothing is created
        plan = {plan, op_chk(MODE_SET, '1, 7, 32'h1234, 0, 0, STATUS_OK, 1)};
        plan = {plan, op_chk(MODE_INC, '1, 7, 5, 0, 0, STATUS_OK, 1)};
        // increment by zero still creates the entry
        plan = {plan, op_chk(MODE_INC, '1, 0, 0, 0, 0, STATUS_OK, 2)};
        plan = {plan, op_chk(MODE_GET, '1, 3, 0, 0, 1, STATUS_OK, 2)};
        plan = {plan, op_chk(MODE_FILTER, '0, 0, 0, 0, 0, STATUS_OK, 2)};
        plan = {plan, reg_row(REG_SAMPLE_COUNT, 4'd8)};
        plan = {plan, op(MODE_SET, 64'h5555_AAAA_0F0F_F0F0, 7, 5)};
        plan = {plan, op(MODE_INC, 64'h5555_AAAA_0F0F_F0F0, 3, 32'h8000_0000)};
        plan = {plan, op(MODE_INC, 64'h5555_AAAA_0F0F_F0F0, 3, 32'h8000_0000)};
        plan = {plan, op(MODE_GET, 64'h5555_AAAA_0F0F_F0F0, 7, 0)};
        plan = {plan, op(MODE_GET, '0, 0, 0)};
        plan = {plan, reg_row(REG_THRESHOLD, 4'd8)};
        plan = {plan, op_chk(MODE_FILTER, '1, 7, 32'hFFFF_FFFF, 0, 0, STATUS_OK, 0)};
        plan = {plan, reg_row(REG_SAMPLE_COUNT, 4'd15)};
        plan = {plan, reg_row(REG_THRESHOLD, 4'd15)};
        plan = {plan, op(MODE_INC, '1, 7, 32'hFFFF_FFFF)};
        plan = {plan, op(MODE_GET, '1, 7, 0)};
        plan = {plan, op_chk(MODE_FILTER, '0, 0, 0, 0, 0, STATUS_OK, 0)};

        foreach (plan[i]) begin
            if (plan[i].is_cfg)
                write_reg(plan[i].cidx, plan[i].cdata);
            else
                send_request(plan[i].req, plan[i].typed, plan[i].want);
        end

        // random traffic under three idling regimes
        for (int ph = 0; ph < 3; ph++) begin
            tx_pct = (ph == 0) ? 29 : (ph == 1) ? 73 : 0;
            rx_pct = (ph == 0) ? 73 : (ph == 1) ? 29 : 0;
            for (int n = 0; n < 267; n++) begin
                if (n % 90 == 0) begin
                    write_reg(REG_SAMPLE_COUNT, CFG_W'($urandom_range(1, 8)));
                    write_reg(REG_THRESHOLD, CFG_W'($urandom_range(0, 8)));
                end
                send_request(random_request(), 1'b0, none);
            end
        end

        // closing sweep with a middle threshold
        write_reg(REG_THRESHOLD, 4'd2);
        send_request(op(MODE_FILTER, '0, 0, 0).req, 1'b0, none);

        drain();
        repeat (20) @(posedge clk);
        $display("%0d requests (%0d sweeps), %0d responses checked", requests_done,
                 filters_sent, responses_seen);
        $display("table-full cases %0d, saturations %0d, mismatches %0d", full_seen,
                 sat_seen, mismatches);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("tb_kmer_count_table: done, clean");
        else
            $display("tb_kmer_count_table: done, errors");
        $finish;
    end

endmodule

/* files.f */
src/kct_pkg.sv
src/kct_ram.sv
src/kct_engine.sv
src/kmer_count_table.sv
src/kct_checker.sv
verif/tb_kmer_count_table.sv
